// ===== src/pimr_pkg.sv =====
// Shared types and widths for the point-in-mesh ray parity block.
// Used by every module under src.
package pimr_pkg;

  localparam int CW   = 32;          // coordinate width
  localparam int DW   = CW + 1;      // edge and offset width
  localparam int PW   = 2 * DW + 1;  // cross product term width
  localparam int QLO  = DW + 1;      // low slice of a cross product term
  localparam int QHI  = PW - QLO;    // high slice of a cross product term
  localparam int MW   = QLO + 1;     // second multiplier operand width
  localparam int AW   = DW + PW + 2; // accumulator width
  localparam int LW   = 32;          // parallel limit width
  localparam int IXW  = 2;           // register index width
  localparam int NSTEP = 16;         // multiply steps per triangle
  localparam int SW   = $clog2(NSTEP);

  localparam logic [IXW-1:0] CFG_POINT_X = IXW'(0);
  localparam logic [IXW-1:0] CFG_POINT_Y = IXW'(1);
  localparam logic [IXW-1:0] CFG_POINT_Z = IXW'(2);
  localparam logic [IXW-1:0] CFG_LIMIT   = IXW'(3);

  typedef struct packed {
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
    logic signed [CW-1:0] v3_x;
    logic signed [CW-1:0] v3_y;
    logic signed [CW-1:0] v3_z;
    logic                 last_triangle;
  } in_word_t;

  typedef struct packed {
    logic crossed;
    logic inside_res;
    logic final_res;
  } out_word_t;

  typedef struct packed {
    logic signed [DW-1:0] e1x;
    logic signed [DW-1:0] e1y;
    logic signed [DW-1:0] e1z;
    logic signed [DW-1:0] e2x;
    logic signed [DW-1:0] e2y;
    logic signed [DW-1:0] e2z;
    logic signed [DW-1:0] sx;
    logic signed [DW-1:0] sy;
    logic signed [DW-1:0] sz;
    logic                 last;
  } job_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== src/pimr_front.sv =====
// Front end: takes triangle words and forms edge and offset vectors.
// Depends on pimr_pkg.
module pimr_front (
  input  pimr_pkg::in_word_t in_word,
  input  pimr_pkg::point_t   point,
  output pimr_pkg::job_t     job
);
  import pimr_pkg::*;

  function automatic logic signed [DW-1:0] ext(input logic signed [CW-1:0] a);
    ext = {a[CW-1], a};
  endfunction

  always_comb begin
    job.e1x  = ext(in_word.v2_x) - ext(in_word.v1_x);
    job.e1y  = ext(in_word.v2_y) - ext(in_word.v1_y);
    job.e1z  = ext(in_word.v2_z) - ext(in_word.v1_z);
    job.e2x  = ext(in_word.v3_x) - ext(in_word.v1_x);
    job.e2y  = ext(in_word.v3_y) - ext(in_word.v1_y);
    job.e2z  = ext(in_word.v3_z) - ext(in_word.v1_z);
    job.sx   = ext(point.x) - ext(in_word.v1_x);
    job.sy   = ext(point.y) - ext(in_word.v1_y);
    job.sz   = ext(point.z) - ext(in_word.v1_z);
    job.last = in_word.last_triangle;
  end

endmodule

// ===== src/pimr_fifo.sv =====
// Two-entry queue of prepared triangles between front and back.
// Depends on pimr_pkg.
module pimr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pimr_pkg::job_t    wr_job,
  input  logic              pop,
  output pimr_pkg::job_t    rd_job,
  output pimr_pkg::q_stat_t stat
);
  import pimr_pkg::*;

  job_t       mem [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_job     = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule

// ===== src/pimr_back.sv =====
// Back end: crossing test on one shared multiplier, parity and result register.
// Depends on pimr_pkg.
module pimr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [pimr_pkg::LW-1:0] limit,
  input  pimr_pkg::job_t       job,
  input  logic                 job_empty,
  output logic                 job_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output pimr_pkg::out_word_t  out_word
);
  import pimr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_NEG   = 5'b01000,
    S_CMP   = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    D_NONE, D_DET, D_UN, D_QX, D_QY, D_QZ
  } dest_t;

  typedef struct packed {
    logic  clr;
    logic  sub;
    logic  hi;
    dest_t dest;
  } mop_t;

  state_t state_r, state_nxt;
  logic [SW-1:0] cnt_r;
  job_t job_r;

  logic signed [DW-1:0]    ma;
  logic signed [MW-1:0]    mb;
  mop_t                    op, op_r;
  logic                    opv_r;
  logic signed [DW+MW-1:0] prod_r;
  logic signed [AW-1:0]    acc_r, addend, sum;
  logic signed [PW-1:0]    det_r, un_r, qx_r, qy_r, qz_r, lim_ext;
  logic signed [PW:0]      uv, det_w;
  logic                    hit, parity_r, out_valid_r, out_wr;
  out_word_t               out_r;

  function automatic logic signed [MW-1:0] dx(input logic signed [DW-1:0] a);
    dx = {{(MW-DW){a[DW-1]}}, a};
  endfunction
  function automatic logic signed [MW-1:0] qlo(input logic signed [PW-1:0] q);
    qlo = {{(MW-QLO){1'b0}}, q[QLO-1:0]};
  endfunction
  function automatic logic signed [MW-1:0] qhi(input logic signed [PW-1:0] q);
    qhi = {{(MW-QHI){q[PW-1]}}, q[PW-1:QLO]};
  endfunction

  always_comb begin
    ma = job_r.e1z;
    mb = dx(job_r.e2y);
    op = '{clr: 1'b1, sub: 1'b0, hi: 1'b0, dest: D_NONE};
    case (cnt_r)
      4'd0: begin ma = job_r.e1z; mb = dx(job_r.e2y); end
      4'd1: begin
        ma = job_r.e1y; mb = dx(job_r.e2z);
        op = '{clr: 1'b0, sub: 1'b1, hi: 1'b0, dest: D_DET};
      end
      4'd2: begin ma = job_r.sz; mb = dx(job_r.e2y); end
      4'd3: begin
        ma = job_r.sy; mb = dx(job_r.e2z);
        op = '{clr: 1'b0, sub: 1'b1, hi: 1'b0, dest: D_UN};
      end
      4'd4: begin ma = job_r.sy; mb = dx(job_r.e1z); end
      4'd5: begin
        ma = job_r.sz; mb = dx(job_r.e1y);
        op = '{clr: 1'b0, sub: 1'b1, hi: 1'b0, dest: D_QX};
      end
      4'd6: begin ma = job_r.sz; mb = dx(job_r.e1x); end
      4'd7: begin
        ma = job_r.sx; mb = dx(job_r.e1z);
        op = '{clr: 1'b0, sub: 1'b1, hi: 1'b0, dest: D_QY};
      end
      4'd8: begin ma = job_r.sx; mb = dx(job_r.e1y); end
      4'd9: begin
        ma = job_r.sy; mb = dx(job_r.e1x);
        op = '{clr: 1'b0, sub: 1'b1, hi: 1'b0, dest: D_QZ};
      end
      4'd10: begin ma = job_r.e2x; mb = qlo(qx_r); end
      4'd11: begin
        ma = job_r.e2x; mb = qhi(qx_r);
        op = '{clr: 1'b0, sub: 1'b0, hi: 1'b1, dest: D_NONE};
      end
      4'd12: begin
        ma = job_r.e2y; mb = qlo(qy_r);
        op = '{clr: 1'b0, sub: 1'b0, hi: 1'b0, dest: D_NONE};
      end
      4'd13: begin
        ma = job_r.e2y; mb = qhi(qy_r);
        op = '{clr: 1'b0, sub: 1'b0, hi: 1'b1, dest: D_NONE};
      end
      4'd14: begin
        ma = job_r.e2z; mb = qlo(qz_r);
        op = '{clr: 1'b0, sub: 1'b0, hi: 1'b0, dest: D_NONE};
      end
      4'd15: begin
        ma = job_r.e2z; mb = qhi(qz_r);
        op = '{clr: 1'b0, sub: 1'b0, hi: 1'b1, dest: D_NONE};
      end
      default: begin end
    endcase
  end

  always_comb begin
    addend = AW'(prod_r);
    if (op_r.hi) begin
      addend = addend <<< QLO;
    end
    if (op_r.sub) begin
      addend = -addend;
    end
    sum = (op_r.clr ? '0 : acc_r) + addend;
  end

  assign lim_ext = $signed({{(PW-LW){1'b0}}, limit});
  assign uv      = {un_r[PW-1], un_r} + {qx_r[PW-1], qx_r};
  assign det_w   = {det_r[PW-1], det_r};
  assign hit     = (det_r > lim_ext) && !un_r[PW-1] && (un_r <= det_r)
                && !qx_r[PW-1] && (uv <= det_w) && !acc_r[AW-1] && (acc_r != '0);

  assign job_pop   = (state_r == S_IDLE) && !job_empty;
  assign out_wr    = (state_r == S_CMP) && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!job_empty) state_nxt = S_MUL;
      S_MUL:   if (cnt_r == SW'(NSTEP - 1)) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_NEG;
      S_NEG:   state_nxt = S_CMP;
      S_CMP:   if (out_wr) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
    end
    prod_r <= (DW+MW)'(ma) * (DW+MW)'(mb);
    op_r   <= op;
    if (opv_r) begin
      acc_r <= sum;
      case (op_r.dest)
        D_DET:   det_r <= sum[PW-1:0];
        D_UN:    un_r  <= sum[PW-1:0];
        D_QX:    qx_r  <= sum[PW-1:0];
        D_QY:    qy_r  <= sum[PW-1:0];
        D_QZ:    qz_r  <= sum[PW-1:0];
        default: begin end
      endcase
    end
    if (state_r == S_NEG && det_r[PW-1]) begin
      det_r <= -det_r;
      un_r  <= -un_r;
      qx_r  <= -qx_r;
      acc_r <= -acc_r;
    end
    if (out_wr) begin
      out_r.crossed    <= hit;
      out_r.inside_res <= parity_r ^ hit;
      out_r.final_res  <= job_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      opv_r       <= 1'b0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      opv_r   <= (state_r == S_MUL);
      cnt_r   <= (state_r == S_MUL) ? cnt_r + SW'(1) : '0;
      if (out_wr) begin
        parity_r    <= job_r.last ? 1'b0 : (parity_r ^ hit);
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_wr_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_wr |=> out_valid_r) else $error("result not presented");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_wr && job_r.last) |=> !parity_r) else $error("parity kept past mesh end");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> $stable(out_r)) else $error("waiting result changed");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && cnt_r == SW'(NSTEP - 1)) |=> state_r == S_DRAIN)
    else $error("multiply sequence overran");

endmodule

// ===== src/point_in_mesh_ray_parity_core.sv =====
// Point-in-mesh ray parity test: top level with configuration registers.
// The back end works on one triangle at a time: the 16 steps of the shared multiplier,
// then drain, negate and compare; the next one is taken once its result is written.
// A two-entry queue holds prepared triangles; input stalls only when it is full.
// Reset (rst_n low, synchronous): point and limit to zero, parity cleared, queues empty.
// Depends on pimr_pkg, pimr_front, pimr_fifo and pimr_back.
module point_in_mesh_ray_parity_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  pimr_pkg::in_word_t        in_word,
  output logic                      out_empty,
  input  logic                      out_pop,
  output pimr_pkg::out_word_t       out_word,
  input  logic                      cfg_we,
  input  logic [pimr_pkg::IXW-1:0]  cfg_idx,
  input  logic [pimr_pkg::LW-1:0]   cfg_wdata
);
  import pimr_pkg::*;

  point_t          point_r;
  logic [LW-1:0]   limit_r;
  job_t            fr_job, q_job;
  q_stat_t         q_stat;
  logic            q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r <= '0;
      limit_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_POINT_X: point_r.x <= cfg_wdata[CW-1:0];
        CFG_POINT_Y: point_r.y <= cfg_wdata[CW-1:0];
        CFG_POINT_Z: point_r.z <= cfg_wdata[CW-1:0];
        CFG_LIMIT:   limit_r   <= cfg_wdata;
        default: begin end
      endcase
    end
  end

  assign in_full = q_stat.full;

  pimr_front u_front (
    .in_word (in_word),
    .point   (point_r),
    .job     (fr_job)
  );

  pimr_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (in_push),
    .wr_job (fr_job),
    .pop    (q_pop),
    .rd_job (q_job),
    .stat   (q_stat)
  );

  pimr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .limit     (limit_r),
    .job       (q_job),
    .job_empty (q_stat.empty),
    .job_pop   (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

// ===== verif/point_in_mesh_ray_parity_core_test.sv =====
// Self-checking testbench for point_in_mesh_ray_parity_core: triangle words against a
// built-in parity predictor, with random push/pop idling and several query point settings.
// Depends on pimr_pkg and the point_in_mesh_ray_parity_core RTL only.
`timescale 1ns / 1ps

module point_in_mesh_ray_parity_core_test;
  import pimr_pkg::*;

  localparam int  LATENCY_WAIT = 30;
  localparam int  CYCLE_LIMIT  = 2000000;
  localparam int  ONE          = 65536;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    in_word_t  tri_w;
    bit        typed;
    out_word_t exp_w;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_word_t  in_word = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic [IXW-1:0] cfg_idx = '0;
  logic [LW-1:0]  cfg_wdata = '0;

  logic signed [CW-1:0] pt_x, pt_y, pt_z;
  logic [LW-1:0]        par_limit;
  bit                   parity;
  out_word_t            expected_q[$];
  bit                   cur_typed;
  out_word_t            cur_exp;
  int                   mismatches;
  int                   cycles;
  int                   tx_idle_pct;
  int                   rx_idle_pct;

  point_in_mesh_ray_parity_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit ray_crosses(in_word_t w);
    wide_t e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
    wide_t det, un, vn, tn, qx, qy, qz;
    e1x = wide_t'($signed(w.v2_x)) - wide_t'($signed(w.v1_x));
    e1y = wide_t'($signed(w.v2_y)) - wide_t'($signed(w.v1_y));
    e1z = wide_t'($signed(w.v2_z)) - wide_t'($signed(w.v1_z));
    e2x = wide_t'($signed(w.v3_x)) - wide_t'($signed(w.v1_x));
    e2y = wide_t'($signed(w.v3_y)) - wide_t'($signed(w.v1_y));
    e2z = wide_t'($signed(w.v3_z)) - wide_t'($signed(w.v1_z));
    sx  = wide_t'(pt_x) - wide_t'($signed(w.v1_x));
    sy  = wide_t'(pt_y) - wide_t'($signed(w.v1_y));
    sz  = wide_t'(pt_z) - wide_t'($signed(w.v1_z));
    det = e1z * e2y - e1y * e2z;
    un  = sz * e2y - sy * e2z;
    qx  = sy * e1z - sz * e1y;
    qy  = sz * e1x - sx * e1z;
    qz  = sx * e1y - sy * e1x;
    vn  = qx;
    tn  = e2x * qx + e2y * qy + e2z * qz;
    if (det < 0) begin
      det = -det;
      un = -un;
      vn = -vn;
      tn = -tn;
    end
    if (det <= $signed({96'b0, par_limit})) return 1'b0;
    if (un < 0 || un > det) return 1'b0;
    if (vn < 0 || un + vn > det) return 1'b0;
    if (tn <= 0) return 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_word_t pred;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && in_push && !in_full) begin
      pred.crossed    = ray_crosses(in_word);
      pred.inside_res = parity ^ pred.crossed;
      pred.final_res  = in_word.last_triangle;
      parity = in_word.last_triangle ? 1'b0 : pred.inside_res;
      expected_q = {expected_q, (cur_typed ? cur_exp : pred)};
    end
    if (rst_n && out_pop && !out_empty) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %b", out_word);
      end else begin
        pred = expected_q.pop_front();
        if (out_word.crossed !== pred.crossed || out_word.inside_res !== pred.inside_res ||
            out_word.final_res !== pred.final_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected crossed=%b inside=%b final=%b, got %b %b %b",
                     pred.crossed, pred.inside_res, pred.final_res,
                     out_word.crossed, out_word.inside_res, out_word.final_res);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_pop = rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_triangle(in_word_t w, bit typed, out_word_t exp_w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push   = 1'b1;
    in_word   = w;
    cur_typed = typed;
    cur_exp   = exp_w;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  task automatic drain;
    in_push = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [IXW-1:0] idx, logic [LW-1:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    case (idx)
      CFG_POINT_X: pt_x = data;
      CFG_POINT_Y: pt_y = data;
      CFG_POINT_Z: pt_z = data;
      CFG_LIMIT:   par_limit = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_point(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                           logic [LW-1:0] lim);
    drain();
    write_reg(CFG_POINT_X, x);
    write_reg(CFG_POINT_Y, y);
    write_reg(CFG_POINT_Z, z);
    write_reg(CFG_LIMIT, lim);
  endtask

  function automatic logic [CW-1:0] near(logic signed [CW-1:0] c, int spread);
    return c + $signed($urandom_range(2 * spread) - spread);
  endfunction

  function automatic in_word_t shaped_triangle(int spread);
    in_word_t w;
    w.v1_x = pt_x + $signed($urandom_range(spread * 8) - spread);
    w.v2_x = pt_x + $signed($urandom_range(spread * 8) - spread);
    w.v3_x = pt_x + $signed($urandom_range(spread * 8) - spread);
    w.v1_y = near(pt_y, spread);
    w.v2_y = near(pt_y, spread);
    w.v3_y = near(pt_y, spread);
    w.v1_z = near(pt_z, spread);
    w.v2_z = near(pt_z, spread);
    w.v3_z = near(pt_z, spread);
    w.last_triangle = 1'b0;
    return w;
  endfunction

  function automatic in_word_t noise_triangle();
    in_word_t w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, 1'($urandom)};
    return w;
  endfunction

  task automatic random_meshes(int count);
    int n, len;
    in_word_t w;
    n = 0;
    while (n < count) begin
      len = $urandom_range(6, 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(99) < 20) w = noise_triangle();
        else w = shaped_triangle(($urandom_range(1) != 0) ? ONE : 1 << 22);
        if ($urandom_range(99) >= 5) w.last_triangle = (k == len - 1);
        send_triangle(w, 1'b0, '0);
        n++;
      end
    end
  endtask

  stim_row_t rows[$];

  initial begin
    stim_row_t r;
    pt_x = '0; pt_y = '0; pt_z = '0; par_limit = '0; parity = 1'b0;
    mismatches = 0; cycles = 0;
    tx_idle_pct = 32; rx_idle_pct = 59;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    r.typed = 1'b1; r.tri_w = '0; r.exp_w = '{1'b0, 1'b0, 1'b0}; rows = {rows, r};
    r.tri_w = '1; r.exp_w = '{1'b0, 1'b0, 1'b1}; rows = {rows, r};
    r.tri_w = {{9{32'sh7FFFFFFF}}, 1'b0}; r.exp_w = '{1'b0, 1'b0, 1'b0}; rows = {rows, r};
    r.tri_w = {{9{32'sh80000000}}, 1'b1}; r.exp_w = '{1'b0, 1'b0, 1'b1}; rows = {rows, r};
    r.typed = 1'b0;
    r.tri_w = {32'(ONE), -32'(ONE), -32'(ONE), 32'(ONE), 32'(3 * ONE), -32'(ONE),
               32'(ONE), -32'(ONE), 32'(3 * ONE), 1'b0};
    rows = {rows, r};
    r.tri_w.last_triangle = 1'b1; rows = {rows, r};
    r.tri_w.v1_x = -ONE; r.tri_w.v2_x = -ONE; r.tri_w.v3_x = -ONE; rows = {rows, r};
    r.tri_w = {32'(ONE), 32'sd0, 32'sd0, 32'(ONE), 32'(ONE), 32'sd0,
               32'(ONE), 32'sd0, 32'(ONE), 1'b0};
    rows = {rows, r};
    r.tri_w = {32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
               32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b0};
    rows = {rows, r};
    r.tri_w.last_triangle = 1'b1; rows = {rows, r};
    r.tri_w = {32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
               32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1};
    rows = {rows, r};
    for (int k = 0; k < 6; k++) begin
      r.tri_w = noise_triangle();
      rows = {rows, r};
    end
    foreach (rows[k]) send_triangle(rows[k].tri_w, rows[k].typed, rows[k].exp_w);

    set_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    foreach (rows[k]) send_triangle(rows[k].tri_w, 1'b0, '0);
    for (int k = 0; k < 40; k++) send_triangle(noise_triangle(), 1'b0, '0);

    set_point($urandom_range(1 << 28) - (1 << 27), $urandom_range(1 << 28) - (1 << 27),
              $urandom_range(1 << 28) - (1 << 27), '0);
    random_meshes(330);

    tx_idle_pct = 59; rx_idle_pct = 32;
    set_point($urandom_range(1 << 28) - (1 << 27), $urandom_range(1 << 28) - (1 << 27),
              $urandom_range(1 << 28) - (1 << 27), $urandom_range(1 << 20));
    random_meshes(330);

    tx_idle_pct = 0; rx_idle_pct = 0;
    set_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, $urandom);
    for (int k = 0; k < 50; k++) send_triangle(noise_triangle(), 1'b0, '0);
    set_point($urandom_range(1 << 28) - (1 << 27), $urandom_range(1 << 28) - (1 << 27),
              $urandom_range(1 << 28) - (1 << 27), $urandom_range(255));
    random_meshes(260);

    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pimr_pkg.sv
src/pimr_front.sv
src/pimr_fifo.sv
src/pimr_back.sv
src/point_in_mesh_ray_parity_core.sv
verif/point_in_mesh_ray_parity_core_test.sv
